FILE: rtl/msde_pkg.sv
// ----------------------------------------------------------------------------
// MIPS subset decode/execute package
// Shared transfer types, opcode and funct codes, and the decode control struct.
// ----------------------------------------------------------------------------
package msde_pkg;

    // Major opcodes, instruction bits 31:26.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // Function codes under the special opcode, instruction bits 5:0.
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    // Instruction class codes.
    localparam logic [1:0] CLASS_NOP = 2'd0;
    localparam logic [1:0] CLASS_R   = 2'd1;
    localparam logic [1:0] CLASS_I   = 2'd2;
    localparam logic [1:0] CLASS_J   = 2'd3;

    localparam logic [4:0] LINK_REG     = 5'd31;
    localparam logic [31:0] PC_REGION   = 32'hf000_0000;
    localparam logic [31:0] SIGN_FLIP   = 32'h8000_0000;

    typedef struct packed {
        logic [31:0]        instr_word;
        logic [31:0]        instr_pc;
        logic signed [31:0] rs_value;
        logic signed [31:0] rt_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] alu_out;
        logic [4:0]         dest_reg;
        logic               reg_write_en;
        logic               mem_read_en;
        logic               mem_write_en;
        logic               mem_to_reg;
        logic               jump_flag;
        logic               br_taken;
        logic [31:0]        target_pc;
        logic [1:0]         inst_class;
    } out_item_t;

    // Decoded fields and control flags handed from decode to execute.
    typedef struct packed {
        logic [5:0]  opcode;
        logic [5:0]  funct;
        logic [4:0]  shamt;
        logic [15:0] imm;
        logic [31:0] imm_sx;
        logic [25:0] jaddr;
        logic        is_jr;
        logic        is_jmp;     // j or jal
        logic        is_beq;
        logic        is_bne;
        logic        is_lw;
        logic        is_sw;
        logic [4:0]  dest_reg;
        logic        reg_write_en;
        logic [1:0]  inst_class;
    } decode_t;

endpackage

FILE: rtl/msde_decode.sv
// ----------------------------------------------------------------------------
// MIPS subset decoder
// Splits the instruction word into fields and derives the control flags.
// ----------------------------------------------------------------------------
module msde_decode (
    input  logic [31:0]      instr_word,
    output msde_pkg::decode_t dec
);

    logic [5:0] opcode;
    logic [5:0] funct;
    logic [4:0] rt;
    logic [4:0] rd;
    logic       is_special;
    logic       is_jal;
    logic       is_j;

    assign opcode     = instr_word[31:26];
    assign funct      = instr_word[5:0];
    assign rt         = instr_word[20:16];
    assign rd         = instr_word[15:11];
    assign is_special = (opcode == msde_pkg::OP_SPECIAL);
    assign is_j       = (opcode == msde_pkg::OP_J);
    assign is_jal     = (opcode == msde_pkg::OP_JAL);

    always_comb
    begin
        dec          = '0;
        dec.opcode   = opcode;
        dec.funct    = funct;
        dec.shamt    = instr_word[10:6];
        dec.imm      = instr_word[15:0];
        dec.imm_sx   = {{16{instr_word[15]}}, instr_word[15:0]};
        dec.jaddr    = instr_word[25:0];
        dec.is_jr    = is_special && (funct == msde_pkg::FN_JR);
        dec.is_jmp   = is_j || is_jal;
        dec.is_beq   = (opcode == msde_pkg::OP_BEQ);
        dec.is_bne   = (opcode == msde_pkg::OP_BNE);
        dec.is_lw    = (opcode == msde_pkg::OP_LW);
        dec.is_sw    = (opcode == msde_pkg::OP_SW);

        priority if (is_jal)
            dec.dest_reg = msde_pkg::LINK_REG;
        else if (is_special)
            dec.dest_reg = rd;
        else
            dec.dest_reg = rt;

        dec.reg_write_en = !(dec.is_sw || dec.is_beq || dec.is_bne || is_j || dec.is_jr);

        priority if (instr_word == 32'd0)
            dec.inst_class = msde_pkg::CLASS_NOP;
        else if (is_special)
            dec.inst_class = msde_pkg::CLASS_R;
        else if (dec.is_jmp)
            dec.inst_class = msde_pkg::CLASS_J;
        else
            dec.inst_class = msde_pkg::CLASS_I;
    end

endmodule

FILE: rtl/msde_execute.sv
// ----------------------------------------------------------------------------
// MIPS subset execute unit
// ALU, branch compare and next-pc selection for one decoded instruction.
// ----------------------------------------------------------------------------
module msde_execute (
    input  msde_pkg::in_item_t  item,
    input  msde_pkg::decode_t   dec,
    output msde_pkg::out_item_t result
);

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc4;
    logic        taken;
    logic [31:0] r_res;
    logic [31:0] res;
    logic [31:0] tgt;

    assign a     = item.rs_value;
    assign b     = item.rt_value;
    assign pc4   = item.instr_pc + 32'd4;
    assign taken = (dec.is_beq && (a == b)) || (dec.is_bne && (a != b));

    // Register-register operations; unknown functs give zero.
    always_comb
    begin
        unique case (dec.funct)
            msde_pkg::FN_ADD, msde_pkg::FN_ADDU: r_res = a + b;
            msde_pkg::FN_SUB, msde_pkg::FN_SUBU: r_res = a - b;
            msde_pkg::FN_AND:  r_res = a & b;
            msde_pkg::FN_OR:   r_res = a | b;
            msde_pkg::FN_NOR:  r_res = ~(a | b);
            msde_pkg::FN_SLT:  r_res = {31'd0, ((a ^ msde_pkg::SIGN_FLIP) <
                                               (b ^ msde_pkg::SIGN_FLIP))};
            msde_pkg::FN_SLTU: r_res = {31'd0, (a < b)};
            msde_pkg::FN_SLL:  r_res = b << dec.shamt;
            msde_pkg::FN_SRL:  r_res = b >> dec.shamt;
            msde_pkg::FN_JR:   r_res = a;
            default:           r_res = 32'd0;
        endcase
    end

    always_comb
    begin
        unique case (dec.opcode)
            msde_pkg::OP_SPECIAL: res = r_res;
            msde_pkg::OP_JAL:     res = item.instr_pc + 32'd8;
            msde_pkg::OP_BEQ, msde_pkg::OP_BNE: res = {31'd0, taken};
            msde_pkg::OP_ADDI, msde_pkg::OP_ADDIU,
            msde_pkg::OP_LW, msde_pkg::OP_SW:   res = a + dec.imm_sx;
            msde_pkg::OP_SLTI:  res = {31'd0, ((a ^ msde_pkg::SIGN_FLIP) <
                                              (dec.imm_sx ^ msde_pkg::SIGN_FLIP))};
            msde_pkg::OP_SLTIU: res = {31'd0, (a < dec.imm_sx)};
            msde_pkg::OP_ANDI:  res = a & {16'd0, dec.imm};
            msde_pkg::OP_ORI:   res = a | {16'd0, dec.imm};
            msde_pkg::OP_LUI:   res = {dec.imm, 16'd0};
            default:            res = 32'd0;
        endcase
    end

    always_comb
    begin
        priority if (dec.is_jmp)
            tgt = (pc4 & msde_pkg::PC_REGION) | {4'd0, dec.jaddr, 2'b00};
        else if (dec.is_jr)
            tgt = a;
        else if (taken)
            tgt = pc4 + {dec.imm_sx[29:0], 2'b00};
        else
            tgt = pc4;
    end

    always_comb
    begin
        result              = '0;
        result.alu_out      = res;
        result.dest_reg     = dec.dest_reg;
        result.reg_write_en = dec.reg_write_en;
        result.mem_read_en  = dec.is_lw;
        result.mem_write_en = dec.is_sw;
        result.mem_to_reg   = dec.is_lw;
        result.jump_flag    = dec.is_jmp || dec.is_jr;
        result.br_taken     = taken;
        result.target_pc    = tgt;
        result.inst_class   = dec.inst_class;
    end

endmodule

FILE: rtl/mips_subset_decode_execute_core.sv
// ----------------------------------------------------------------------------
// MIPS subset decode and execute core
// Registered decode/ALU stage for the MIPS32 integer subset.
// ----------------------------------------------------------------------------
// This block takes one instruction word, its pc and the two source register
// values in each transfer and returns one result transfer holding the ALU
// result, the destination register and write enable, the memory controls,
// the jump and branch-taken flags, the next pc and the instruction class.
// The path is an input register, one pass of decode and execute logic, and an
// output register, so each result is registered from its input transfer in
// the input register and then in the output register, and the block sustains
// one instruction per cycle while the receiver takes results. The throughput
// is set by the single execute pass between the two registers: both may hold
// items at once, and while a finished result waits the input register can
// still take one more transfer, after which the input stalls until the
// result leaves. Overflow is never trapped, srl is logical, sltu and sltiu
// compare unsigned, and branch targets are pc + 4 + offset * 4.
module mips_subset_decode_execute_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  msde_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output msde_pkg::out_item_t result
);

    // Input register stage.
    msde_pkg::in_item_t  s1_reg;
    logic                s1_valid_reg;
    logic                s1_valid_next;

    // Output register stage.
    msde_pkg::out_item_t result_reg;
    logic                result_valid_reg;
    logic                result_valid_next;

    msde_pkg::decode_t   dec;
    msde_pkg::out_item_t exec_result;

    logic                out_load;
    logic                in_load;

    // The output register can take a new result when it is empty or its
    // current result leaves in this cycle.
    assign out_load   = !result_valid_reg || result_ready;
    // The input register can take a transfer when it is empty or its item
    // moves into the output register in this cycle.
    assign item_ready = !s1_valid_reg || out_load;
    assign in_load    = item_valid && item_ready;

    msde_decode u_decode (
        .instr_word (s1_reg.instr_word),
        .dec        (dec)
    );

    msde_execute u_execute (
        .item   (s1_reg),
        .dec    (dec),
        .result (exec_result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_load)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (out_load)
            result_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_load)
            s1_reg <= item;
        if (out_load && s1_valid_reg)
            result_reg <= exec_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A held input item always reaches the output register once it is free.
    a_s1_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_load) |=> result_valid_reg)
        else $error("input stage item did not reach the output register");

    // A stalled result is not overwritten by the item behind it.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |=> $stable(result_reg))
        else $error("stalled result changed");

    // Loads and stores are exclusive, and a load always selects memory data.
    a_mem_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!(result_reg.mem_read_en && result_reg.mem_write_en)
                              && (result_reg.mem_to_reg == result_reg.mem_read_en)))
        else $error("inconsistent memory controls");

    // A jump is never also a taken branch, and jump-class items always jump.
    a_flow_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!(result_reg.jump_flag && result_reg.br_taken)
                              && ((result_reg.inst_class != msde_pkg::CLASS_J)
                                  || result_reg.jump_flag)))
        else $error("inconsistent jump and branch flags");

endmodule

FILE: dv/tb_mips_subset_decode_execute_core.sv
// ----------------------------------------------------------------------------
// Testbench for the MIPS subset decode and execute core
// Sends instruction transfers, predicts each result in the bench and
// compares every result field, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_mips_subset_decode_execute_core;

    // A funct or opcode that the subset does not define.
    localparam logic [5:0] FN_UNUSED = 6'h3f;
    localparam logic [5:0] OP_UNUSED = 6'h3f;

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 4000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    msde_pkg::in_item_t  item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    msde_pkg::out_item_t result;

    // Results predicted for accepted instructions, oldest first.
    msde_pkg::out_item_t exec_results_due [$];
    int        mismatch_count = 0;

    // Percent of cycles in which the sender idles or the receiver stalls.
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    // Cycles left in a forced receiver hold-off.
    int        hold_off_left = 0;
    int        quiet_cycles = 0;

    logic [5:0] known_fns [12] = '{msde_pkg::FN_SLL, msde_pkg::FN_SRL, msde_pkg::FN_JR,
                                   msde_pkg::FN_ADD, msde_pkg::FN_ADDU, msde_pkg::FN_SUB,
                                   msde_pkg::FN_SUBU, msde_pkg::FN_AND, msde_pkg::FN_OR,
                                   msde_pkg::FN_NOR, msde_pkg::FN_SLT, msde_pkg::FN_SLTU};
    logic [5:0] known_ops [13] = '{msde_pkg::OP_J, msde_pkg::OP_JAL, msde_pkg::OP_BEQ,
                                   msde_pkg::OP_BNE, msde_pkg::OP_ADDI, msde_pkg::OP_ADDIU,
                                   msde_pkg::OP_SLTI, msde_pkg::OP_SLTIU, msde_pkg::OP_ANDI,
                                   msde_pkg::OP_ORI, msde_pkg::OP_LUI, msde_pkg::OP_LW,
                                   msde_pkg::OP_SW};

    mips_subset_decode_execute_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Instruction word builders.
    // ------------------------------------------------------------------------
    function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                           logic [4:0] sh, logic [5:0] fn);
        return {msde_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] j_word(logic [5:0] op, logic [25:0] addr);
        return {op, addr};
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: decodes the word and runs the ALU exactly as the core should.
    // All sums wrap at 32 bits; srl is logical and sltiu compares unsigned against
    // the sign-extended immediate.
    // ------------------------------------------------------------------------
    function automatic msde_pkg::out_item_t execute_instr(msde_pkg::in_item_t it);
        logic [31:0] w, pc, a, b, sx, pc4, res, tgt;
        logic [5:0]  op, fn;
        logic [4:0]  rt, rd, sh;
        logic [15:0] imm;
        logic        is_jr, is_jmp, is_beq, is_bne, is_lw, is_sw, taken;
        msde_pkg::out_item_t r;
        w      = it.instr_word;
        pc     = it.instr_pc;
        a      = it.rs_value;
        b      = it.rt_value;
        op     = w[31:26];
        rt     = w[20:16];
        rd     = w[15:11];
        sh     = w[10:6];
        fn     = w[5:0];
        imm    = w[15:0];
        sx     = {{16{imm[15]}}, imm};
        pc4    = pc + 32'd4;
        is_jr  = (op == msde_pkg::OP_SPECIAL) && (fn == msde_pkg::FN_JR);
        is_jmp = (op == msde_pkg::OP_J) || (op == msde_pkg::OP_JAL);
        is_beq = (op == msde_pkg::OP_BEQ);
        is_bne = (op == msde_pkg::OP_BNE);
        is_lw  = (op == msde_pkg::OP_LW);
        is_sw  = (op == msde_pkg::OP_SW);
        taken  = (is_beq && (a == b)) || (is_bne && (a != b));

        case (op)
            msde_pkg::OP_SPECIAL:
            begin
                case (fn)
                    msde_pkg::FN_ADD, msde_pkg::FN_ADDU: res = a + b;
                    msde_pkg::FN_SUB, msde_pkg::FN_SUBU: res = a - b;
                    msde_pkg::FN_AND:  res = a & b;
                    msde_pkg::FN_OR:   res = a | b;
                    msde_pkg::FN_NOR:  res = ~(a | b);
                    msde_pkg::FN_SLT:  res = {31'd0, $signed(a) < $signed(b)};
                    msde_pkg::FN_SLTU: res = {31'd0, a < b};
                    msde_pkg::FN_SLL:  res = b << sh;
                    msde_pkg::FN_SRL:  res = b >> sh;
                    msde_pkg::FN_JR:   res = a;
                    default:           res = 32'd0;
                endcase
            end
            msde_pkg::OP_JAL:                    res = pc + 32'd8;
            msde_pkg::OP_BEQ, msde_pkg::OP_BNE:  res = {31'd0, taken};
            msde_pkg::OP_ADDI, msde_pkg::OP_ADDIU,
            msde_pkg::OP_LW, msde_pkg::OP_SW:    res = a + sx;
            msde_pkg::OP_SLTI:  res = {31'd0, $signed(a) < $signed(sx)};
            msde_pkg::OP_SLTIU: res = {31'd0, a < sx};
            msde_pkg::OP_ANDI:  res = a & {16'd0, imm};
            msde_pkg::OP_ORI:   res = a | {16'd0, imm};
            msde_pkg::OP_LUI:   res = {imm, 16'd0};
            default:            res = 32'd0;
        endcase

        if (is_jmp)
            tgt = {pc4[31:28], w[25:0], 2'b00};
        else if (is_jr)
            tgt = a;
        else if (taken)
            tgt = pc4 + (sx << 2);
        else
            tgt = pc4;

        r.alu_out      = res;
        r.dest_reg     = (op == msde_pkg::OP_JAL) ? msde_pkg::LINK_REG :
                         ((op == msde_pkg::OP_SPECIAL) ? rd : rt);
        r.reg_write_en = !(is_sw || is_beq || is_bne || (op == msde_pkg::OP_J) || is_jr);
        r.mem_read_en  = is_lw;
        r.mem_write_en = is_sw;
        r.mem_to_reg   = is_lw;
        r.jump_flag    = is_jmp || is_jr;
        r.br_taken     = taken;
        r.target_pc    = tgt;
        if (w == 32'd0)
            r.inst_class = msde_pkg::CLASS_NOP;
        else if (op == msde_pkg::OP_SPECIAL)
            r.inst_class = msde_pkg::CLASS_R;
        else if (is_jmp)
            r.inst_class = msde_pkg::CLASS_J;
        else
            r.inst_class = msde_pkg::CLASS_I;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Called at a clock edge; returns at the edge where the transfer
    // is taken, leaving valid high so the next call can follow back to back.
    // ------------------------------------------------------------------------
    task automatic send_instr(input logic [31:0] word, input logic [31:0] pc,
                              input logic [31:0] a, input logic [31:0] b);
        msde_pkg::in_item_t it;
        it.instr_word = word;
        it.instr_pc   = pc;
        it.rs_value   = a;
        it.rt_value   = b;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        exec_results_due.push_back(execute_instr(it));
    endtask

    // ------------------------------------------------------------------------
    // Receiver and checker. Values are read right at the edge, before the
    // core's registers update, so each check sees the transfer as it happened.
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input msde_pkg::out_item_t got);
        msde_pkg::out_item_t want;
        if (exec_results_due.size() == 0)
        begin
            $error("result transfer with no instruction outstanding");
            mismatch_count++;
        end
        else
        begin
            want = exec_results_due.pop_front();
            compare_field("alu_out", want.alu_out, got.alu_out);
            compare_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
            compare_field("reg_write_en", 32'(want.reg_write_en), 32'(got.reg_write_en));
            compare_field("mem_read_en", 32'(want.mem_read_en), 32'(got.mem_read_en));
            compare_field("mem_write_en", 32'(want.mem_write_en), 32'(got.mem_write_en));
            compare_field("mem_to_reg", 32'(want.mem_to_reg), 32'(got.mem_to_reg));
            compare_field("jump_flag", 32'(want.jump_flag), 32'(got.jump_flag));
            compare_field("br_taken", 32'(want.br_taken), 32'(got.br_taken));
            compare_field("target_pc", want.target_pc, got.target_pc);
            compare_field("inst_class", 32'(want.inst_class), 32'(got.inst_class));
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                check_result(result);
            // A forced hold-off overrides the random stall pattern.
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any transfer on either side counts as progress.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Random stimulus. Most items are well-formed instructions of the subset
    // with random fields; the rest are all-zero words, random words, random
    // opcodes and random functs, which may be undefined.
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'hffff_ffff;
            4:       return 32'($urandom_range(255));
            default: return $urandom();
        endcase
    endfunction

    function automatic msde_pkg::in_item_t rand_instr();
        msde_pkg::in_item_t it;
        logic [5:0]  op, fn;
        logic [15:0] imm;
        int          pick;
        pick        = $urandom_range(99);
        it.rs_value = rand_operand();
        it.rt_value = rand_operand();
        case ($urandom_range(3))
            0:       it.instr_pc = $urandom();
            1:       it.instr_pc = 32'hffff_ff00 | (32'($urandom_range(255)) & 32'hfc);
            default: it.instr_pc = $urandom() & 32'hffff_fffc;
        endcase
        case ($urandom_range(7))
            0:       imm = 16'h0000;
            1:       imm = 16'hffff;
            2:       imm = 16'h8000;
            3:       imm = 16'h7fff;
            default: imm = 16'($urandom_range(16'hffff));
        endcase
        op = msde_pkg::OP_SPECIAL;
        fn = known_fns[$urandom_range(11)];
        if (pick < 2)
            it.instr_word = 32'd0;
        else if (pick < 10)
            it.instr_word = $urandom();
        else if (pick < 50)
        begin
            if (pick < 14)
                fn = 6'($urandom_range(63));
            it.instr_word = r_word(5'($urandom_range(31)), 5'($urandom_range(31)),
                                   5'($urandom_range(31)), 5'($urandom_range(31)), fn);
        end
        else
        begin
            op = (pick < 53) ? 6'($urandom_range(63)) : known_ops[$urandom_range(12)];
            if ((op == msde_pkg::OP_J) || (op == msde_pkg::OP_JAL))
                it.instr_word = j_word(op, 26'($urandom()));
            else
                it.instr_word = i_word(op, 5'($urandom_range(31)),
                                       5'($urandom_range(31)), imm);
        end
        // Equal operands exercise the branch decision and put compares on the boundary.
        if ((op == msde_pkg::OP_BEQ || op == msde_pkg::OP_BNE
             || fn == msde_pkg::FN_SLT || fn == msde_pkg::FN_SLTU)
            && $urandom_range(1))
            it.rt_value = it.rs_value;
        return it;
    endfunction

    task automatic run_random(input int count);
        msde_pkg::in_item_t it;
        repeat (count)
        begin
            it = rand_instr();
            send_instr(it.instr_word, it.instr_pc, it.rs_value, it.rt_value);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Every operation at least once, with the field extremes and the corner cases:
    // wrapping sums, the all-zero word, undefined funct and opcode, logical
    // shift right, unsigned compares, branch targets that wrap.
    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_instr(32'd0, 32'h0000_0100, 32'h1234_5678, 32'h8765_4321);
        send_instr(r_word(5'd1, 5'd2, 5'd31, 5'd0, msde_pkg::FN_ADD), 32'd0,
                   32'h7fff_ffff, 32'd1);
        send_instr(r_word(5'd3, 5'd4, 5'd5, 5'd0, msde_pkg::FN_ADDU), 32'd4,
                   32'hffff_ffff, 32'd1);
        send_instr(r_word(5'd1, 5'd2, 5'd3, 5'd0, msde_pkg::FN_SUB), 32'd8,
                   32'h8000_0000, 32'd1);
        send_instr(r_word(5'd1, 5'd2, 5'd3, 5'd0, msde_pkg::FN_SUBU), 32'd12,
                   32'd0, 32'd1);
        send_instr(r_word(5'd1, 5'd2, 5'd3, 5'd0, msde_pkg::FN_AND), 32'd16,
                   32'hffff_ffff, 32'ha5a5_a5a5);
        send_instr(r_word(5'd1, 5'd2, 5'd3, 5'd0, msde_pkg::FN_OR), 32'd20,
                   32'h0f0f_0000, 32'h0000_f0f0);
        send_instr(r_word(5'd0, 5'd0, 5'd7, 5'd0, msde_pkg::FN_NOR), 32'd24,
                   32'd0, 32'd0);
        send_instr(r_word(5'd1, 5'd2, 5'd3, 5'd0, msde_pkg::FN_SLT), 32'd28,
                   32'h8000_0000, 32'h7fff_ffff);
        send_instr(r_word(5'd1, 5'd2, 5'd3, 5'd0, msde_pkg::FN_SLTU), 32'd32,
                   32'h8000_0000, 32'h7fff_ffff);
        send_instr(r_word(5'd0, 5'd2, 5'd3, 5'd31, msde_pkg::FN_SLL), 32'd36,
                   32'd0, 32'd1);
        send_instr(r_word(5'd0, 5'd2, 5'd3, 5'd31, msde_pkg::FN_SRL), 32'd40,
                   32'd0, 32'h8000_0000);
        send_instr(r_word(5'd31, 5'd0, 5'd0, 5'd0, msde_pkg::FN_JR), 32'd44,
                   32'hdead_beef, 32'd0);
        send_instr(r_word(5'd31, 5'd31, 5'd0, 5'd31, FN_UNUSED), 32'd48, 32'hffff_ffff,
                   32'hffff_ffff);
        send_instr(i_word(msde_pkg::OP_ADDI, 5'd1, 5'd2, 16'h8000), 32'd52,
                   32'h8000_0000, 32'd0);
        send_instr(i_word(msde_pkg::OP_ADDIU, 5'd1, 5'd2, 16'h7fff), 32'd56,
                   32'h7fff_ffff, 32'd0);
        send_instr(i_word(msde_pkg::OP_SLTI, 5'd1, 5'd2, 16'hffff), 32'd60,
                   32'h8000_0000, 32'd0);
        send_instr(i_word(msde_pkg::OP_SLTIU, 5'd1, 5'd2, 16'hffff), 32'd64,
                   32'h7fff_ffff, 32'd0);
        send_instr(i_word(msde_pkg::OP_ANDI, 5'd1, 5'd2, 16'hffff), 32'd68,
                   32'hffff_ffff, 32'd0);
        send_instr(i_word(msde_pkg::OP_ORI, 5'd1, 5'd2, 16'h8001), 32'd72,
                   32'h0001_0000, 32'd0);
        send_instr(i_word(msde_pkg::OP_LUI, 5'd0, 5'd9, 16'hffff), 32'd76,
                   32'd0, 32'd0);
        send_instr(i_word(msde_pkg::OP_LW, 5'd29, 5'd31, 16'hfffc), 32'd80,
                   32'h0000_0002, 32'd0);
        send_instr(i_word(msde_pkg::OP_SW, 5'd29, 5'd31, 16'h0004), 32'd84,
                   32'hffff_fffc, 32'd5);
        // Taken branches whose targets wrap below zero and above the top, and one not taken.
        send_instr(i_word(msde_pkg::OP_BEQ, 5'd1, 5'd2, 16'h8000), 32'd0,
                   32'h1234, 32'h1234);
        send_instr(i_word(msde_pkg::OP_BNE, 5'd1, 5'd2, 16'h7fff), 32'hffff_fff0,
                   32'd1, 32'd2);
        send_instr(i_word(msde_pkg::OP_BEQ, 5'd1, 5'd2, 16'h0010), 32'd88,
                   32'd1, 32'd2);
        // pc + 4 wraps to zero, so the jump region comes from the wrapped value.
        send_instr(j_word(msde_pkg::OP_J, 26'h3ff_ffff), 32'hffff_fffc, 32'd0, 32'd0);
        send_instr(j_word(msde_pkg::OP_JAL, 26'h000_0001), 32'h7fff_fff8, 32'd0, 32'd0);
        send_instr({OP_UNUSED, 26'h3ff_ffff}, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(470);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 65;
        recv_stall_pct = 0;
        run_random(470);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        run_random(470);
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        run_random(470);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so both registers fill and the core stops taking input.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 60;
        run_random(40);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_output_backpressure();
        // Drain: stop offering, let every outstanding result arrive, then keep
        // watching for stray results.
        item_valid     <= 1'b0;
        recv_stall_pct = 0;
        while (exec_results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/msde_pkg.sv
rtl/msde_decode.sv
rtl/msde_execute.sv
rtl/mips_subset_decode_execute_core.sv
dv/tb_mips_subset_decode_execute_core.sv
